/* design/bsrp_pkg.sv */
// ----------------------------------------------------------------------------
// bsrp_pkg
// Shared constants, types and width helpers of the box screen rect projector.
// ----------------------------------------------------------------------------
package bsrp_pkg;

    localparam int DEFAULT_FRAC_BITS = 16;
    localparam int COORD_W           = 32;
    localparam int MAT_W             = 64;
    localparam int DIM_W             = 15;
    localparam int CFG_ADDR_W        = 3;

    // Saturation limit of the perspective divide is 2^SAT_SHIFT.
    localparam int SAT_SHIFT = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_R0_C01 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_R0_C23 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_R1_C01 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_R1_C23 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_R3_C01 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_R3_C23 = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_TGT_W  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_TGT_H  = 3'd7;

    typedef enum logic [1:0] {
        VIS_VISIBLE   = 2'd0,
        VIS_BEHIND    = 2'd1,
        VIS_STRADDLE  = 2'd2,
        VIS_OFFSCREEN = 2'd3
    } vis_t;

    // Width of a clip coordinate: three floored products plus a constant term.
    function automatic int clip_w(input int frac_bits);
        return 2 * COORD_W + 2 - frac_bits;
    endfunction

endpackage

/* design/bsrp_sat_div.sv */
// ----------------------------------------------------------------------------
// bsrp_sat_div
// Pipelined saturating signed divide, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bsrp_sat_div
    import bsrp_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS,
    parameter int IN_W      = clip_w(DEFAULT_FRAC_BITS)
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [IN_W-1:0]     num,
    input  logic signed [IN_W-1:0]     den,
    output logic signed [FRAC_BITS+4:0] quot
);

    localparam int NQ = FRAC_BITS + SAT_SHIFT;
    localparam int QW = FRAC_BITS + 5;
    localparam int RW = IN_W + 3;

    logic [RW-1:0] rem_reg [0:NQ];
    logic [RW-1:0] dv_reg  [0:NQ];
    logic [NQ-1:0] q_reg   [0:NQ];
    logic          neg_reg [0:NQ];
    logic          sat_reg [0:NQ];
    logic signed [QW-1:0] quot_reg;

    logic [IN_W-1:0] mag;
    logic            sat_now;
    logic [NQ:0]     mq;

    // Magnitude and the saturation test |num| >= 8 * den.
    always_comb begin
        mag     = num[IN_W-1] ? IN_W'(-num) : num;
        sat_now = {3'b000, mag} >= {den, 3'b000};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= RW'(mag);
            dv_reg[0]  <= RW'({den, 2'b00});
            q_reg[0]   <= '0;
            neg_reg[0] <= num[IN_W-1];
            sat_reg[0] <= sat_now;
        end
    end

    // The divisor starts at four times den so the first step yields the 4s bit.
    for (genvar i = 0; i < NQ; i++) begin : g_step
        logic          ge;
        logic [RW-1:0] r2;
        always_comb begin
            ge = rem_reg[i] >= dv_reg[i];
            r2 = ge ? rem_reg[i] - dv_reg[i] : rem_reg[i];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1] <= {r2[RW-2:0], 1'b0};
                dv_reg[i+1]  <= dv_reg[i];
                q_reg[i+1]   <= {q_reg[i][NQ-2:0], ge};
                neg_reg[i+1] <= neg_reg[i];
                sat_reg[i+1] <= sat_reg[i];
            end
        end
    end

    always_comb begin
        mq = sat_reg[NQ] ? ((NQ+1)'(1) << NQ) : {1'b0, q_reg[NQ]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg <= neg_reg[NQ] ? -QW'(mq) : QW'(mq);
        end
    end

    assign quot = quot_reg;

endmodule

/* design/box_screen_rect_projector.sv */
// ----------------------------------------------------------------------------
// box_screen_rect_projector
// Projects an axis-aligned box to the pixel rectangle that covers it.
// ----------------------------------------------------------------------------
// Usage: each item on the s_ channel is one box (min and max corners, signed
// fixed point). The block transforms all eight corners with rows 0, 1 and 3
// of the configured view-projection matrix, divides x and y by w for corners
// in front of the eye, takes the extremes and maps them to pixels of the
// target. Each box produces exactly one item on the m_ channel: the rect in
// tdata and the visibility code in tuser.
// Throughput is one box per clock cycle while the skid register is empty.
// A box passes the matrix products and sums, the bit-per-stage divider, the
// min/max tree, pixel mapping and the output register before m_tvalid.
// The divider is the long part; its depth follows the quotient width.
// Reset clears all valid bits and loads the identity matrix and a 1920x1080
// target; s_tready stays low while reset is held. Configuration is written
// through cfg_we/cfg_addr/cfg_wdata and must only change while no box is in
// flight.
// When the receiver stalls, the result waits in the output register and one
// more result can land in a skid register; only then does s_tready drop and
// the whole pipeline hold, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module box_screen_rect_projector
    import bsrp_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [6*COORD_W-1:0]  s_tdata,
    // rect_left, rect_top, rect_width, rect_height, zero fill
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,
    // visibility
    output logic [1:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [MAT_W-1:0]      cfg_wdata
);

    localparam int CW      = clip_w(FRAC_BITS);
    localparam int QW      = FRAC_BITS + 5;
    localparam int DIV_LAT = FRAC_BITS + SAT_SHIFT + 2;
    localparam int PW      = QW + 17;

    localparam logic signed [CW-1:0] W_EPS =
        CW'(((64'sd1 <<< FRAC_BITS) + 64'sd50000) / 64'sd100000);
    localparam logic signed [QW-1:0] ONE_Q     = QW'(1) << FRAC_BITS;
    localparam logic signed [QW-1:0] NEG_ONE_Q = -ONE_Q;
    localparam logic [PW-1:0]        RND_UP    = (PW'(1) << (FRAC_BITS + 1)) - PW'(1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MAT_W-1:0] mat_reg [0:5];
    logic [DIM_W-1:0] tgt_w_reg, tgt_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg[0] <= 64'd65536;
            mat_reg[1] <= 64'd0;
            mat_reg[2] <= 64'd65536 << 32;
            mat_reg[3] <= 64'd0;
            mat_reg[4] <= 64'd0;
            mat_reg[5] <= 64'd65536 << 32;
            tgt_w_reg  <= DIM_W'(1920);
            tgt_h_reg  <= DIM_W'(1080);
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_R0_C01: mat_reg[0] <= cfg_wdata;
                CFG_R0_C23: mat_reg[1] <= cfg_wdata;
                CFG_R1_C01: mat_reg[2] <= cfg_wdata;
                CFG_R1_C23: mat_reg[3] <= cfg_wdata;
                CFG_R3_C01: mat_reg[4] <= cfg_wdata;
                CFG_R3_C23: mat_reg[5] <= cfg_wdata;
                CFG_TGT_W:  tgt_w_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_TGT_H:  tgt_h_reg  <= cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Matrix rows used here are 0, 1 and 3; they sit at rows 0, 1, 2 below.
    logic signed [31:0] m_coef [0:2][0:3];
    logic signed [31:0] box_c  [0:1][0:2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            m_coef[r][0] = mat_reg[2*r][31:0];
            m_coef[r][1] = mat_reg[2*r][63:32];
            m_coef[r][2] = mat_reg[2*r+1][31:0];
            m_coef[r][3] = mat_reg[2*r+1][63:32];
        end
        for (int h = 0; h < 2; h++) begin
            for (int k = 0; k < 3; k++) begin
                box_c[h][k] = s_tdata[(3*h+k)*COORD_W +: COORD_W];
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: everything advances unless the skid is occupied.
    // ------------------------------------------------------------------
    logic en;
    logic skid_valid_reg, out_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en && aresetn;

    // Stage 1: the 18 distinct coefficient by coordinate products.
    logic signed [63:0] prod_reg [0:2][0:2][0:1];
    logic               v1_reg, v2_reg, v3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    for (int h = 0; h < 2; h++) begin
                        prod_reg[r][k][h] <= m_coef[r][k] * box_c[h][k];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stages 2 and 3: floored products summed into clip x, y and w per corner.
    logic signed [CW-1:0] p01_reg  [0:7][0:2];
    logic signed [CW-1:0] p23_reg  [0:7][0:2];
    logic signed [CW-1:0] clip_reg [0:7][0:2];
    logic signed [QW-1:0] ndc      [0:7][0:1];
    logic [7:0]           beh_now;

    for (genvar c = 0; c < 8; c++) begin : g_corner
        localparam int HX = c % 2;
        localparam int HY = (c / 2) % 2;
        localparam int HZ = (c / 4) % 2;
        for (genvar r = 0; r < 3; r++) begin : g_row
            always_ff @(posedge aclk) begin
                if (en) begin
                    p01_reg[c][r]  <= CW'(prod_reg[r][0][HX] >>> FRAC_BITS)
                                    + CW'(prod_reg[r][1][HY] >>> FRAC_BITS);
                    p23_reg[c][r]  <= CW'(prod_reg[r][2][HZ] >>> FRAC_BITS)
                                    + CW'(m_coef[r][3]);
                    clip_reg[c][r] <= p01_reg[c][r] + p23_reg[c][r];
                end
            end
        end

        assign beh_now[c] = clip_reg[c][2] <= W_EPS;

        for (genvar a = 0; a < 2; a++) begin : g_axis
            bsrp_sat_div #(
                .FRAC_BITS (FRAC_BITS),
                .IN_W      (CW)
            ) u_div (
                .aclk (aclk),
                .en   (en),
                .num  (clip_reg[c][a]),
                .den  (clip_reg[c][2]),
                .quot (ndc[c][a])
            );
        end
    end

    // Behind flags and valid bits ride alongside the dividers.
    logic [7:0]         beh_pipe_reg [0:DIV_LAT-1];
    logic [DIV_LAT-1:0] vd_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            beh_pipe_reg[0] <= beh_now;
            for (int i = 1; i < DIV_LAT; i++) begin
                beh_pipe_reg[i] <= beh_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= '0;
        end else if (en) begin
            vd_reg <= {vd_reg[DIV_LAT-2:0], v3_reg};
        end
    end

    // ------------------------------------------------------------------
    // Min/max tree. A corner behind the eye contributes the start values
    // (+1 for the minimum, -1 for the maximum), which also seed the tree.
    // ------------------------------------------------------------------
    function automatic logic signed [QW-1:0] smin(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [QW-1:0] smax(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    logic [7:0]           beh_d;
    logic signed [QW-1:0] cmin [0:1][0:7];
    logic signed [QW-1:0] cmax [0:1][0:7];

    always_comb begin
        beh_d = beh_pipe_reg[DIV_LAT-1];
        for (int a = 0; a < 2; a++) begin
            for (int c = 0; c < 8; c++) begin
                cmin[a][c] = beh_d[c] ? ONE_Q : smin(ndc[c][a], ONE_Q);
                cmax[a][c] = beh_d[c] ? NEG_ONE_Q : smax(ndc[c][a], NEG_ONE_Q);
            end
        end
    end

    logic signed [QW-1:0] mn1_reg [0:1][0:3];
    logic signed [QW-1:0] mx1_reg [0:1][0:3];
    logic signed [QW-1:0] mn2_reg [0:1][0:1];
    logic signed [QW-1:0] mx2_reg [0:1][0:1];
    logic signed [QW-1:0] mn3_reg [0:1];
    logic signed [QW-1:0] mx3_reg [0:1];
    logic [2:0]           allb_reg, anyb_reg;
    logic [2:0]           vm_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 2; a++) begin
                for (int j = 0; j < 4; j++) begin
                    mn1_reg[a][j] <= smin(cmin[a][2*j], cmin[a][2*j+1]);
                    mx1_reg[a][j] <= smax(cmax[a][2*j], cmax[a][2*j+1]);
                end
                for (int j = 0; j < 2; j++) begin
                    mn2_reg[a][j] <= smin(mn1_reg[a][2*j], mn1_reg[a][2*j+1]);
                    mx2_reg[a][j] <= smax(mx1_reg[a][2*j], mx1_reg[a][2*j+1]);
                end
                mn3_reg[a] <= smin(mn2_reg[a][0], mn2_reg[a][1]);
                mx3_reg[a] <= smax(mx2_reg[a][0], mx2_reg[a][1]);
            end
            allb_reg <= {allb_reg[1:0], &beh_d};
            anyb_reg <= {anyb_reg[1:0], |beh_d};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= '0;
        end else if (en) begin
            vm_reg <= {vm_reg[1:0], vd_reg[DIV_LAT-1]};
        end
    end

    // ------------------------------------------------------------------
    // Pixel mapping: p = (n + 1) * size, then clamp and scale by 1/2.
    // Index 0 left, 1 right, 2 top, 3 bottom.
    // ------------------------------------------------------------------
    function automatic logic signed [PW-1:0] pix_mul(input logic signed [QW-1:0] n,
                                                     input logic [DIM_W-1:0]     size);
        logic signed [QW:0] nb;
        nb = (QW+1)'(n) + (QW+1)'(ONE_Q);
        return PW'(nb) * PW'($signed({1'b0, size}));
    endfunction

    function automatic logic [PW-1:0] pix_clamp(input logic signed [PW-1:0] p,
                                                input logic [DIM_W-1:0]     size);
        logic [PW-1:0] hi_u;
        hi_u = PW'(size) << (FRAC_BITS + 1);
        if (p < 0) begin
            return '0;
        end else if ($unsigned(p) > hi_u) begin
            return hi_u;
        end
        return $unsigned(p);
    endfunction

    logic signed [PW-1:0] pix_reg [0:3];
    logic                 allb_p_reg, anyb_p_reg, off_p_reg;
    logic                 vp1_reg, vp2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_reg[0] <= pix_mul(mn3_reg[0], tgt_w_reg);
            pix_reg[1] <= pix_mul(mx3_reg[0], tgt_w_reg);
            pix_reg[2] <= pix_mul(mn3_reg[1], tgt_h_reg);
            pix_reg[3] <= pix_mul(mx3_reg[1], tgt_h_reg);
            allb_p_reg <= allb_reg[2];
            anyb_p_reg <= anyb_reg[2];
            off_p_reg  <= (mx3_reg[0] < NEG_ONE_Q) || (mn3_reg[0] > ONE_Q)
                       || (mx3_reg[1] < NEG_ONE_Q) || (mn3_reg[1] > ONE_Q);
        end
    end

    logic [PW-1:0]    pc [0:3];
    logic [DIM_W-1:0] l_reg, r_reg, t_reg, b_reg;
    logic             allb_q_reg, anyb_q_reg, off_q_reg;

    always_comb begin
        pc[0] = pix_clamp(pix_reg[0], tgt_w_reg);
        pc[1] = pix_clamp(pix_reg[1], tgt_w_reg);
        pc[2] = pix_clamp(pix_reg[2], tgt_h_reg);
        pc[3] = pix_clamp(pix_reg[3], tgt_h_reg);
    end

    // Start edges round down, end edges round up.
    always_ff @(posedge aclk) begin
        if (en) begin
            l_reg      <= DIM_W'(pc[0] >> (FRAC_BITS + 1));
            r_reg      <= DIM_W'((pc[1] + RND_UP) >> (FRAC_BITS + 1));
            t_reg      <= DIM_W'(pc[2] >> (FRAC_BITS + 1));
            b_reg      <= DIM_W'((pc[3] + RND_UP) >> (FRAC_BITS + 1));
            allb_q_reg <= allb_p_reg;
            anyb_q_reg <= anyb_p_reg;
            off_q_reg  <= off_p_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp1_reg <= 1'b0;
            vp2_reg <= 1'b0;
        end else if (en) begin
            vp1_reg <= vm_reg[2];
            vp2_reg <= vp1_reg;
        end
    end

    // Final result selection.
    logic [63:0] e_tdata;
    vis_t        e_vis;

    always_comb begin
        e_tdata = '0;
        if (allb_q_reg) begin
            e_vis = VIS_BEHIND;
        end else if (anyb_q_reg) begin
            e_vis = VIS_STRADDLE;
            e_tdata[44:30] = tgt_w_reg;
            e_tdata[59:45] = tgt_h_reg;
        end else if (off_q_reg) begin
            e_vis = VIS_OFFSCREEN;
        end else begin
            e_vis = VIS_VISIBLE;
            e_tdata[14:0]  = l_reg;
            e_tdata[29:15] = t_reg;
            e_tdata[44:30] = (r_reg >= l_reg) ? r_reg - l_reg : '0;
            e_tdata[59:45] = (b_reg >= t_reg) ? b_reg - t_reg : '0;
        end
    end

    // ------------------------------------------------------------------
    // Output register with one skid entry.
    // ------------------------------------------------------------------
    logic [63:0] out_tdata_reg, skid_tdata_reg;
    vis_t        out_vis_reg, skid_vis_reg;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_free) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (vp2_reg) begin
            if (out_free) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_free) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_free) begin
                out_tdata_reg <= skid_tdata_reg;
                out_vis_reg   <= skid_vis_reg;
            end
        end else if (vp2_reg) begin
            if (out_free) begin
                out_tdata_reg <= e_tdata;
                out_vis_reg   <= e_vis;
            end else begin
                skid_tdata_reg <= e_tdata;
                skid_vis_reg   <= e_vis;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_vis_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a pending output");

    a_skid_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled while the output was free");

    a_behind_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == VIS_BEHIND) |-> (m_tdata == 64'd0))
        else $error("all-behind result carries a nonzero rect");

    a_never_offscreen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != VIS_OFFSCREEN))
        else $error("extremes escaped their start values");

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the box screen rect projector. Boxes are sent
// under random idling and a long receiver hold-off. A bit-exact predictor
// computes the rect for every accepted box, and each result is compared field
// by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;
    import bsrp_pkg::*;

    localparam int       FB    = DEFAULT_FRAC_BITS;
    localparam longint   ONE   = longint'(1) << FB;
    // Epsilon of the behind-the-eye test: 1e-5 rounded to the nearest LSB.
    localparam longint   W_EPS = (ONE + 50000) / 100000;
    localparam int       SETTLE = 2 * FB + 40;

    typedef struct packed {
        logic [DIM_W-1:0] left;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        vis_t             vis;
    } rect_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [6*COORD_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [63:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_R0_C01;
    logic [MAT_W-1:0]      cfg_wdata = '0;

    box_screen_rect_projector u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Local copy of the register file, kept in step with every write.
    logic [MAT_W-1:0] mat_regs [6];
    logic [DIM_W-1:0] tgt_w, tgt_h;

    rect_t  pending_rects [$];
    int     mismatches = 0;
    bit     quiet_lines = 1'b0;   // no idling on either side while set
    bit     hold_off = 1'b0;      // receiver stalls for a long stretch

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint sx(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    // One matrix row times a corner: each product floored to FB fraction
    // bits, column 3 added as the constant term.
    function automatic longint clip_row(input logic [63:0] c01, input logic [63:0] c23,
                                        input longint px, input longint py,
                                        input longint pz);
        return ((sx(c01[31:0]) * px) >>> FB) + ((sx(c01[63:32]) * py) >>> FB)
             + ((sx(c23[31:0]) * pz) >>> FB) + sx(c23[63:32]);
    endfunction

    // Perspective divide, saturated at +-8 and truncated toward zero.
    function automatic longint persp_div(input longint x, input longint w);
        longint unsigned mag, q, rem;
        mag = (x < 0) ? longint'(-x) : longint'(x);
        if (mag >= longint'(8) * w) begin
            q = longint'(8) << FB;
        end else begin
            q = mag / w;
            rem = mag % w;
            for (int i = 0; i < FB; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= w) begin
                    rem = rem - w;
                    q = q | 1;
                end
            end
        end
        return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned to_pixels(input longint n, input logic [DIM_W-1:0] sz);
        longint p, top;
        p = (n + ONE) * longint'(sz);
        top = 2 * ONE * longint'(sz);
        if (p < 0) p = 0;
        if (p > top) p = top;
        return p;
    endfunction

    function automatic rect_t project_box(input logic [6*COORD_W-1:0] box);
        longint lo [3], hi [3];
        longint px, py, pz, cw, nx, ny;
        longint mnx, mny, mxx, mxy;
        longint unsigned d, l, t, r, b;
        int behind;
        rect_t res;
        mnx = ONE; mny = ONE; mxx = -ONE; mxy = -ONE;
        behind = 0;
        res = '0;
        for (int k = 0; k < 3; k++) begin
            lo[k] = sx(box[k*32 +: 32]);
            hi[k] = sx(box[(k+3)*32 +: 32]);
        end
        for (int c = 0; c < 8; c++) begin
            px = c[0] ? hi[0] : lo[0];
            py = c[1] ? hi[1] : lo[1];
            pz = c[2] ? hi[2] : lo[2];
            cw = clip_row(mat_regs[4], mat_regs[5], px, py, pz);
            if (cw <= W_EPS) begin
                behind++;
            end else begin
                nx = persp_div(clip_row(mat_regs[0], mat_regs[1], px, py, pz), cw);
                ny = persp_div(clip_row(mat_regs[2], mat_regs[3], px, py, pz), cw);
                if (nx < mnx) mnx = nx;
                if (nx > mxx) mxx = nx;
                if (ny < mny) mny = ny;
                if (ny > mxy) mxy = ny;
            end
        end
        if (behind == 8) begin
            res.vis = VIS_BEHIND;
        end else if (behind > 0) begin
            res.width = tgt_w;
            res.height = tgt_h;
            res.vis = VIS_STRADDLE;
        end else if (mxx < -ONE || mnx > ONE || mxy < -ONE || mny > ONE) begin
            res.vis = VIS_OFFSCREEN;
        end else begin
            d = 2 * ONE;
            l = to_pixels(mnx, tgt_w) / d;
            t = to_pixels(mny, tgt_h) / d;
            r = (to_pixels(mxx, tgt_w) + d - 1) / d;
            b = (to_pixels(mxy, tgt_h) + d - 1) / d;
            res.left = l[DIM_W-1:0];
            res.top = t[DIM_W-1:0];
            res.width = (r >= l) ? DIM_W'(r - l) : '0;
            res.height = (b >= t) ? DIM_W'(b - t) : '0;
            res.vis = VIS_VISIBLE;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_lines || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_box(input logic [6*COORD_W-1:0] box);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= box;
        do @(posedge aclk); while (!s_tready);
        pending_rects = {pending_rects, project_box(box)};
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [MAT_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_TGT_W) tgt_w = val[DIM_W-1:0];
        else if (idx == CFG_TGT_H) tgt_h = val[DIM_W-1:0];
        else mat_regs[idx] = val;
    endtask

    // Lets every box in flight drain before the configuration changes.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_rects.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [MAT_W-1:0] pack_row(input longint a, input longint b);
        return {b[31:0], a[31:0]};
    endfunction

    task automatic set_matrix(input longint m [12], input int w, input int h);
        write_reg(CFG_R0_C01, pack_row(m[0], m[1]));
        write_reg(CFG_R0_C23, pack_row(m[2], m[3]));
        write_reg(CFG_R1_C01, pack_row(m[4], m[5]));
        write_reg(CFG_R1_C23, pack_row(m[6], m[7]));
        write_reg(CFG_R3_C01, pack_row(m[8], m[9]));
        write_reg(CFG_R3_C23, pack_row(m[10], m[11]));
        write_reg(CFG_TGT_W, MAT_W'(w));
        write_reg(CFG_TGT_H, MAT_W'(h));
    endtask

    function automatic logic [6*COORD_W-1:0] mk_box(input longint x0, input longint y0,
                                                   input longint z0, input longint x1,
                                                   input longint y1, input longint z1);
        return {z1[31:0], y1[31:0], x1[31:0], z0[31:0], y0[31:0], x0[31:0]};
    endfunction

    function automatic longint rnd_coord();
        case ($urandom_range(0, 3))
            0: return sx($urandom());
            1: return longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
            2: return longint'($urandom_range(0, 64 * ONE)) - 32 * ONE;
            default: return longint'($urandom_range(0, 512)) - 256;
        endcase
    endfunction

    // A well-formed box from a random corner point; about one in ten is raw noise.
    function automatic logic [6*COORD_W-1:0] rnd_box();
        longint c [3], e [3];
        if ($urandom_range(0, 9) == 0)
            return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        for (int k = 0; k < 3; k++) begin
            c[k] = rnd_coord();
            e[k] = longint'($urandom_range(0, 3 * ONE));
            if (c[k] + e[k] > 64'sh7FFF_FFFF) c[k] = 64'sh7FFF_FFFF - e[k];
        end
        return mk_box(c[0], c[1], c[2], c[0] + e[0], c[1] + e[1], c[2] + e[2]);
    endfunction

    function automatic longint rnd_entry();
        if ($urandom_range(0, 7) == 0) return sx($urandom());
        return longint'($urandom_range(0, 4 * ONE)) - 2 * ONE;
    endfunction

    function automatic int rnd_dim();
        case ($urandom_range(0, 5))
            0: return 1;
            1: return 16384;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_identity();
        // Identity matrix, w fixed at one, 1920x1080 target.
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(-ONE, -ONE, 0, ONE, ONE, 0));
        send_box(mk_box(-ONE / 2, -ONE / 4, 5, ONE / 3, ONE / 2, 9));
        // Fully left of the target: a zero-width rect at its edge.
        send_box(mk_box(-3 * ONE, 0, 0, -2 * ONE, ONE / 2, 0));
        // Extremes of every field, far beyond the saturation limit.
        send_box(mk_box(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                        64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF));
        send_box({6{32'hFFFF_FFFF}});
        send_box({6{32'h8000_0000}});
        send_box({6{32'h7FFF_FFFF}});
        drain();
    endtask

    task automatic test_perspective();
        longint m [12];
        // Row 3 picks z as w, so the box depth decides the eye cases.
        m = '{ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0};
        set_matrix(m, 640, 480);
        send_box(mk_box(-ONE, -ONE, -2 * ONE, ONE, ONE, -ONE));     // all behind
        send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));          // straddles
        send_box(mk_box(-ONE, -ONE, 2 * ONE, ONE, ONE, 4 * ONE));   // visible
        send_box(mk_box(0, 0, W_EPS, ONE, ONE, W_EPS));              // w at epsilon
        send_box(mk_box(ONE, -ONE, W_EPS + 1, ONE, ONE, W_EPS + 1)); // tiny w, saturates
        send_box(mk_box(-ONE, -ONE, 0, ONE, ONE, ONE));              // one face at w = 0
        drain();
        // Smallest and largest targets.
        set_matrix(m, 1, 1);
        send_box(mk_box(-ONE / 3, -ONE / 3, ONE, ONE / 5, ONE / 7, 2 * ONE));
        send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
        drain();
        set_matrix(m, 16384, 16384);
        send_box(mk_box(-ONE / 3, -ONE / 3, ONE, ONE / 5, ONE / 7, 2 * ONE));
        send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_box(mk_box(-8 * ONE, -8 * ONE, ONE, 8 * ONE, 8 * ONE, ONE));
        drain();
    endtask

    task automatic test_backpressure();
        longint m [12];
        m = '{ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 3 * ONE};
        set_matrix(m, 1280, 720);
        // The receiver stops for a long stretch while boxes keep coming, so
        // the pipeline fills and s_tready has to drop.
        quiet_lines = 1'b1;
        hold_off = 1'b1;
        repeat (60) send_box(rnd_box());
        quiet_lines = 1'b0;
        drain();
    endtask

    task automatic test_random(input int phases, input int per_phase);
        longint m [12];
        for (int p = 0; p < phases; p++) begin
            for (int k = 0; k < 12; k++) m[k] = rnd_entry();
            // Most phases keep a projective row 3 so all eye cases show up.
            if ($urandom_range(0, 3) != 0) begin
                m[8] = 0;
                m[9] = 0;
                m[10] = $urandom_range(0, 1) ? ONE : -ONE;
                m[11] = longint'($urandom_range(0, 8 * ONE)) - 2 * ONE;
            end
            set_matrix(m, rnd_dim(), rnd_dim());
            quiet_lines = (p % 4 == 3);
            repeat (per_phase) send_box(rnd_box());
            quiet_lines = 1'b0;
            drain();
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, with one long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin
        int n;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            n = hold_off ? 300 : gap_len();
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n - 1) @(posedge aclk);
                hold_off = 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Checker: each result against the oldest pending prediction.
    always @(posedge aclk) begin
        rect_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[14:0], m_tdata[29:15], m_tdata[44:30], m_tdata[59:45],
                   vis_t'(m_tuser)};
            if (pending_rects.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_rects.pop_front();
                if (got !== want || m_tdata[63:60] !== 4'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp l%0d t%0d w%0d h%0d v%0d, ",
                                  "got l%0d t%0d w%0d h%0d v%0d"},
                                 want.left, want.top, want.width, want.height, want.vis,
                                 got.left, got.top, got.width, got.height, got.vis);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        mat_regs[0] = 64'd65536;
        mat_regs[1] = '0;
        mat_regs[2] = 64'd65536 << 32;
        mat_regs[3] = '0;
        mat_regs[4] = '0;
        mat_regs[5] = 64'd65536 << 32;
        tgt_w = 15'd1920;
        tgt_h = 15'd1080;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_identity();
        test_perspective();
        test_backpressure();
        test_random(8, 130);
        drain();
        if (mismatches == 0 && pending_rects.size() == 0) begin
            $display("** box_screen_rect_projector: PASSED **");
        end else begin
            $display("** box_screen_rect_projector: FAILED **");
        end
        $finish;
    end

    // Watchdog, far above the slowest legal run.
    initial begin
        #20000000;
        $display("** box_screen_rect_projector: FAILED **");
        $finish;
    end

endmodule
